FILE: hw/rtl/cpc_pkg.sv
// Shared constants for the contour person classifier.
// Configuration register codes, field widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package cpc_pkg;

  localparam int COORD_BITS_DEFAULT = 10;
  localparam int MAX_GROUP_DEFAULT  = 20;

  localparam int AREA_CFG_W  = 13;
  localparam int ASPECT_W    = 9;
  localparam int EST_W       = 5;
  localparam int PERCENT_W   = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_AREA       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_AREA       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ASPECT_PERCENT = 2'd2;

  localparam logic [AREA_CFG_W-1:0] MIN_AREA_RESET       = 13'd499;
  localparam logic [AREA_CFG_W-1:0] MAX_AREA_RESET       = 13'd750;
  localparam logic [ASPECT_W-1:0]   ASPECT_PERCENT_RESET = 9'd99;

  localparam logic [PERCENT_W-1:0]  PERCENT_SCALE = 7'd100;
  localparam logic [EST_W-1:0]      EST_SINGLE    = 5'd1;
  localparam logic [EST_W-1:0]      EST_NONE      = 5'd0;

endpackage

FILE: hw/rtl/cpc_point_if.sv
// Input channel carrying one contour vertex per transaction.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

interface cpc_point_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

FILE: hw/rtl/cpc_result_if.sv
// Output channel carrying one classification result per transaction.
// Uses cpc_pkg for the estimate width.
`timescale 1ns / 1ps

interface cpc_result_if #(
  parameter int COORD_BITS = 10
);
  logic                            valid;
  logic                            ready;
  logic                            is_person;
  logic [cpc_pkg::EST_W-1:0]       person_estimate;
  logic [2*COORD_BITS:0]           twice_area;
  logic [COORD_BITS-1:0]           box_width;
  logic [COORD_BITS-1:0]           box_height;

  modport source (output valid, output is_person, output person_estimate,
                  output twice_area, output box_width, output box_height,
                  input ready);
  modport sink (input valid, input is_person, input person_estimate,
                input twice_area, input box_width, input box_height,
                output ready);
endinterface

FILE: hw/rtl/contour_person_classifier_core.sv
// Contour person classifier: bounding box, shoelace area and person/group test.
// Uses cpc_pkg, cpc_point_if and cpc_result_if.
//
//   channel   direction  transaction            payload
//   point     in         one contour vertex     point_x, point_y, last_point
//   result    out        one per last vertex    is_person, person_estimate,
//                                               twice_area, box_width, box_height
//   cfg       in         register write         cfg_index, cfg_data
//
// One vertex is accepted per cycle unless a last vertex waits in s1. The cross
// products are taken in the accept cycle; results pass s2, s3 and the output register.
// Vertices that end no contour keep flowing while a result waits on the output.
// Synchronous active-high reset resets contour state, pipeline valids and config registers.
`timescale 1ns / 1ps

module contour_person_classifier_core #(
  parameter int COORD_BITS = cpc_pkg::COORD_BITS_DEFAULT,
  parameter int MAX_GROUP  = cpc_pkg::MAX_GROUP_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  cpc_point_if.sink                       point,
  cpc_result_if.source                    result
);

  localparam int SUM_W     = 2 * COORD_BITS + 3;
  localparam int AREA_W    = 2 * COORD_BITS + 1;
  localparam int PROD_W    = 2 * COORD_BITS;
  localparam int HALF_W    = 2 * COORD_BITS;
  localparam int GROUP_W   = $clog2(MAX_GROUP + 1);
  localparam int BOUND_W   = cpc_pkg::AREA_CFG_W + 1 + GROUP_W;
  localparam int CMP_W     = (AREA_W > BOUND_W) ? AREA_W : BOUND_W;
  localparam int HC_W      = (HALF_W > cpc_pkg::AREA_CFG_W) ? HALF_W : cpc_pkg::AREA_CFG_W;
  localparam int EST_CALC_W = (GROUP_W > cpc_pkg::EST_W) ? GROUP_W : cpc_pkg::EST_W;
  localparam int HP_W      = COORD_BITS + cpc_pkg::PERCENT_W;
  localparam int WP_W      = COORD_BITS + cpc_pkg::ASPECT_W;
  localparam int RATIO_W   = (HP_W > WP_W) ? HP_W : WP_W;

  logic [cpc_pkg::AREA_CFG_W-1:0] min_area;
  logic [cpc_pkg::AREA_CFG_W-1:0] max_area;
  logic [cpc_pkg::ASPECT_W-1:0]   aspect_percent;
  logic [BOUND_W-1:0]             lo_bound [MAX_GROUP];
  logic [BOUND_W-1:0]             hi_bound [MAX_GROUP];

  logic                  in_contour;
  logic [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic [COORD_BITS-1:0] low_x, low_y, high_x, high_y;
  logic [COORD_BITS-1:0] fx, fy, low_x_next, low_y_next, high_x_next, high_y_next;
  logic [PROD_W-1:0]     prod_a, prod_b, prod_c, prod_d;
  logic                  accept, start;

  logic                  s1_valid, s1_start, s1_last;
  logic [SUM_W-1:0]      s1_term, s1_close;
  logic [COORD_BITS-1:0] s1_width, s1_height;
  logic [SUM_W-1:0]      acc, acc_next, total;
  logic                  s1_go, s1_free;

  logic                  s2_valid;
  logic [SUM_W-1:0]      s2_total;
  logic [COORD_BITS-1:0] s2_width, s2_height;
  logic [SUM_W-1:0]      mag;
  logic [AREA_W-1:0]     twice;
  logic                  s2_free;

  logic                  s3_valid;
  logic [AREA_W-1:0]     s3_twice;
  logic [COORD_BITS-1:0] s3_width, s3_height;
  logic [HP_W-1:0]       s3_hprod;
  logic [WP_W-1:0]       s3_wprod;
  logic                  s3_free;
  logic [HALF_W-1:0]     half;
  logic                  person, below;
  logic [EST_CALC_W-1:0] best, est;

  logic                  out_valid, out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_area       <= cpc_pkg::MIN_AREA_RESET;
      max_area       <= cpc_pkg::MAX_AREA_RESET;
      aspect_percent <= cpc_pkg::ASPECT_PERCENT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cpc_pkg::CFG_MIN_AREA:       min_area       <= cfg_data[cpc_pkg::AREA_CFG_W-1:0];
        cpc_pkg::CFG_MAX_AREA:       max_area       <= cfg_data[cpc_pkg::AREA_CFG_W-1:0];
        cpc_pkg::CFG_ASPECT_PERCENT: aspect_percent <= cfg_data[cpc_pkg::ASPECT_W-1:0];
        default: ;
      endcase
    end
  end

  // Group bounds are registered from the area registers and follow them in the next cycle.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_GROUP; i++) begin
      lo_bound[i] <= (BOUND_W'(min_area) << 1) * BOUND_W'(i + 1);
      hi_bound[i] <= (BOUND_W'(max_area) << 1) * BOUND_W'(i + 1);
    end
  end

  assign out_free    = !out_valid || result.ready;
  assign s3_free     = !s3_valid || out_free;
  assign s2_free     = !s2_valid || s3_free;
  assign s1_go       = s1_valid && (!s1_last || s2_free);
  assign s1_free     = !s1_valid || s1_go;
  assign point.ready = s1_free;
  assign accept      = point.valid && s1_free;
  assign start       = !in_contour;

  always_comb begin
    fx = start ? point.point_x : first_x;
    fy = start ? point.point_y : first_y;
    low_x_next  = (start || point.point_x < low_x)  ? point.point_x : low_x;
    low_y_next  = (start || point.point_y < low_y)  ? point.point_y : low_y;
    high_x_next = (start || point.point_x > high_x) ? point.point_x : high_x;
    high_y_next = (start || point.point_y > high_y) ? point.point_y : high_y;
    prod_a = prev_x * point.point_y;
    prod_b = point.point_x * prev_y;
    prod_c = point.point_x * fy;
    prod_d = fx * point.point_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_contour <= 1'b0;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      low_x      <= '1;
      low_y      <= '1;
      high_x     <= '0;
      high_y     <= '0;
    end else if (accept) begin
      in_contour <= !point.last_point;
      first_x    <= fx;
      first_y    <= fy;
      prev_x     <= point.point_x;
      prev_y     <= point.point_y;
      low_x      <= low_x_next;
      low_y      <= low_y_next;
      high_x     <= high_x_next;
      high_y     <= high_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start  <= start;
      s1_last   <= point.last_point;
      s1_term   <= SUM_W'(prod_a) - SUM_W'(prod_b);
      s1_close  <= SUM_W'(prod_c) - SUM_W'(prod_d);
      s1_width  <= high_x_next - low_x_next;
      s1_height <= high_y_next - low_y_next;
    end
  end

  always_comb begin
    acc_next = s1_start ? '0 : acc + s1_term;
    total    = acc_next + s1_close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_go) begin
        acc <= acc_next;
      end
      if (s2_free) begin
        s2_valid <= s1_go && s1_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      s2_total  <= total;
      s2_width  <= s1_width;
      s2_height <= s1_height;
    end
  end

  always_comb begin
    mag   = s2_total[SUM_W-1] ? (SUM_W'(0) - s2_total) : s2_total;
    twice = (|mag[SUM_W-1:AREA_W]) ? {AREA_W{1'b1}} : mag[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_free) begin
      s3_twice  <= twice;
      s3_width  <= s2_width;
      s3_height <= s2_height;
      s3_hprod  <= HP_W'(s2_height) * HP_W'(cpc_pkg::PERCENT_SCALE);
      s3_wprod  <= WP_W'(s2_width) * WP_W'(aspect_percent);
    end
  end

  always_comb begin
    half   = s3_twice[AREA_W-1:1];
    person = (HC_W'(half) > HC_W'(min_area)) && (HC_W'(half) < HC_W'(max_area)) &&
             (s3_width != '0) && (RATIO_W'(s3_hprod) > RATIO_W'(s3_wprod));
    below  = CMP_W'(s3_twice) < (CMP_W'(min_area) << 1);
    best   = EST_CALC_W'(cpc_pkg::EST_SINGLE);
    for (int k = 0; k < MAX_GROUP; k++) begin
      if (CMP_W'(s3_twice) > CMP_W'(lo_bound[k]) && CMP_W'(s3_twice) < CMP_W'(hi_bound[k])) begin
        best = EST_CALC_W'(k + 1);
      end
    end
    if (person) begin
      est = EST_CALC_W'(cpc_pkg::EST_SINGLE);
    end else if (below) begin
      est = EST_CALC_W'(cpc_pkg::EST_NONE);
    end else begin
      est = best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && out_free) begin
      result.is_person       <= person;
      result.person_estimate <= est[cpc_pkg::EST_W-1:0];
      result.twice_area      <= s3_twice;
      result.box_width       <= s3_width;
      result.box_height      <= s3_height;
    end
  end

  assign result.valid = out_valid;

endmodule

FILE: hw/rtl/cpc_checker.sv
// Port-level assertions for the contour person classifier, bound to the top level.
// Uses cpc_pkg; watches only the top-level ports.
`timescale 1ns / 1ps

module cpc_checker #(
  parameter int COORD_BITS = cpc_pkg::COORD_BITS_DEFAULT
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      is_person,
  input logic [cpc_pkg::EST_W-1:0] person_estimate,
  input logic [2*COORD_BITS:0]     twice_area,
  input logic [COORD_BITS-1:0]     box_width,
  input logic [COORD_BITS-1:0]     box_height
);

  // A stalled result transaction keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(is_person) &&
      $stable(person_estimate) && $stable(twice_area) && $stable(box_width) &&
      $stable(box_height))
    else $error("result payload changed during a stall");

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A single person always reports an estimate of one.
  a_person_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_person |-> person_estimate == cpc_pkg::EST_SINGLE)
    else $error("person result with estimate other than one");

  // A person needs a nonzero box width and an area of at least one pixel.
  a_person_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_person |-> box_width != '0 && twice_area > 1)
    else $error("person result with empty box or area");

endmodule

bind contour_person_classifier_core cpc_checker #(
  .COORD_BITS(COORD_BITS)
) u_cpc_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .is_person       (result.is_person),
  .person_estimate (result.person_estimate),
  .twice_area      (result.twice_area),
  .box_width       (result.box_width),
  .box_height      (result.box_height)
);

FILE: bench/contour_person_classifier_core_tb.sv
// Testbench for contour_person_classifier_core: streams contour vertices, predicts
// each verdict in a scoreboard class and checks every result transaction against it.
// Depends on cpc_pkg, cpc_point_if, cpc_result_if and the core itself.
`timescale 1ns / 1ps

module contour_person_classifier_core_tb;

  localparam int CB = cpc_pkg::COORD_BITS_DEFAULT;
  localparam int SUM_W = 2 * CB + 3;
  localparam int AREA_W = 2 * CB + 1;
  localparam int EST_W = cpc_pkg::EST_W;
  localparam int MAX_GROUP = cpc_pkg::MAX_GROUP_DEFAULT;
  localparam longint AREA_CAP = (64'd1 << AREA_W) - 1;
  localparam int PHASE_POINTS = 310;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_AFTER = 700;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic              is_person;
    logic [EST_W-1:0]  estimate;
    logic [AREA_W-1:0] twice_area;
    logic [CB-1:0]     width;
    logic [CB-1:0]     height;
  } verdict_t;

  class contour_verdicts;
    int min_area;
    int max_area;
    int aspect;
    logic [CB-1:0] first_x, first_y, prev_x, prev_y;
    logic [CB-1:0] low_x, low_y, high_x, high_y;
    logic [SUM_W-1:0] acc;
    bit tracing;
    verdict_t awaited[$];
    int mismatches;

    function new();
      min_area = cpc_pkg::MIN_AREA_RESET;
      max_area = cpc_pkg::MAX_AREA_RESET;
      aspect = cpc_pkg::ASPECT_PERCENT_RESET;
      tracing = 0;
      acc = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [cpc_pkg::CFG_INDEX_W-1:0] idx, int val);
      case (idx)
        cpc_pkg::CFG_MIN_AREA: min_area = val & 32'h1fff;
        cpc_pkg::CFG_MAX_AREA: max_area = val & 32'h1fff;
        cpc_pkg::CFG_ASPECT_PERCENT: aspect = val & 32'h1ff;
        default: ;
      endcase
    endfunction

    function logic [SUM_W-1:0] cross_prod(logic [CB-1:0] ax, logic [CB-1:0] ay,
                                          logic [CB-1:0] bx, logic [CB-1:0] by);
      longint p;
      p = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
      return SUM_W'(p);
    endfunction

    function int group_count(longint twice);
      int best;
      best = int'(cpc_pkg::EST_SINGLE);
      if (twice < 2 * longint'(min_area)) return int'(cpc_pkg::EST_NONE);
      for (int k = 1; k <= MAX_GROUP; k++) begin
        if (twice > 2 * longint'(min_area) * k && twice < 2 * longint'(max_area) * k) best = k;
      end
      return best;
    endfunction

    function void take_vertex(logic [CB-1:0] x, logic [CB-1:0] y, bit last);
      logic [SUM_W-1:0] closing;
      longint twice;
      longint half;
      logic [CB-1:0] w, h;
      bit person;
      verdict_t v;
      if (!tracing) begin
        first_x = x; first_y = y;
        prev_x = x; prev_y = y;
        low_x = x; low_y = y;
        high_x = x; high_y = y;
        acc = '0;
        tracing = 1;
      end else begin
        acc = acc + cross_prod(prev_x, prev_y, x, y);
        if (x < low_x) low_x = x;
        if (y < low_y) low_y = y;
        if (x > high_x) high_x = x;
        if (y > high_y) high_y = y;
        prev_x = x; prev_y = y;
      end
      if (!last) return;
      closing = acc + cross_prod(x, y, first_x, first_y);
      if (closing[SUM_W-1]) twice = (longint'(1) << SUM_W) - longint'(closing);
      else twice = longint'(closing);
      if (twice > AREA_CAP) twice = AREA_CAP;
      w = high_x - low_x;
      h = high_y - low_y;
      half = twice >> 1;
      person = half > min_area && half < max_area && w != 0 &&
               100 * longint'(h) > longint'(aspect) * longint'(w);
      v.is_person = person;
      if (person) v.estimate = cpc_pkg::EST_SINGLE;
      else v.estimate = EST_W'(group_count(twice));
      v.twice_area = AREA_W'(twice);
      v.width = w;
      v.height = h;
      awaited = {awaited, v};
      tracing = 0;
    endfunction

    function void match_verdict(verdict_t got);
      verdict_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: person=%0d est=%0d area2=%0d w=%0d h=%0d",
                   got.is_person, got.estimate, got.twice_area, got.width, got.height);
        return;
      end
      want = awaited.pop_front();
      if (got.is_person !== want.is_person || got.estimate !== want.estimate ||
          got.twice_area !== want.twice_area || got.width !== want.width ||
          got.height !== want.height) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("verdict mismatch, expected: person=%0d est=%0d area2=%0d w=%0d h=%0d",
                   want.is_person, want.estimate, want.twice_area, want.width, want.height);
          $display("                  actual:   person=%0d est=%0d area2=%0d w=%0d h=%0d",
                   got.is_person, got.estimate, got.twice_area, got.width, got.height);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [cpc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [cpc_pkg::CFG_DATA_W-1:0] cfg_data;

  cpc_point_if #(.COORD_BITS(CB)) pin ();
  cpc_result_if #(.COORD_BITS(CB)) rout ();

  contour_person_classifier_core u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .point(pin),
    .result(rout)
  );

  contour_verdicts sb = new();
  int points_taken = 0;
  int phase_points = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_point(input int x, input int y, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pin.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    pin.valid <= 1'b1;
    pin.point_x <= CB'(x);
    pin.point_y <= CB'(y);
    pin.last_point <= last;
    do @(posedge clk); while (pin.ready !== 1'b1);
    sb.take_vertex(CB'(x), CB'(y), last);
    points_taken++;
    phase_points++;
    burst_left--;
  endtask

  task automatic send_contour(input int xs[$], input int ys[$]);
    for (int i = 0; i < xs.size(); i++) send_point(xs[i], ys[i], i == xs.size() - 1);
  endtask

  task automatic pause_until_drained(input int settle);
    pin.valid <= 1'b0;
    burst_left = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cpc_pkg::CFG_INDEX_W-1:0] idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cpc_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_limits(input int min_a, input int max_a, input int asp);
    write_reg(cpc_pkg::CFG_MIN_AREA, min_a);
    write_reg(cpc_pkg::CFG_MAX_AREA, max_a);
    write_reg(cpc_pkg::CFG_ASPECT_PERCENT, asp);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic square_windings(input int lo, input int hi, input int turns);
    int xs[$];
    int ys[$];
    repeat (turns) begin
      xs = {xs, lo}; ys = {ys, lo};
      xs = {xs, hi}; ys = {ys, lo};
      xs = {xs, hi}; ys = {ys, hi};
      xs = {xs, lo}; ys = {ys, hi};
    end
    send_contour(xs, ys);
  endtask

  task automatic random_contour();
    int kind, n, w, h, x0, y0, span, s, idx, nxt;
    bit rev;
    int cx[4];
    int cy[4];
    int xs[$];
    int ys[$];
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      w = $urandom_range(1, 70);
      h = $urandom_range(1, 140);
      x0 = $urandom_range(0, 1023 - w);
      y0 = $urandom_range(0, 1023 - h);
      cx = '{x0, x0 + w, x0 + w, x0};
      cy = '{y0, y0, y0 + h, y0 + h};
      s = $urandom_range(0, 3);
      rev = $urandom_range(0, 1);
      for (int i = 0; i < 4; i++) begin
        idx = rev ? (s - i + 4) % 4 : (s + i) % 4;
        xs = {xs, cx[idx]}; ys = {ys, cy[idx]};
        if (i == 1 && $urandom_range(0, 2) == 0) begin
          nxt = rev ? (s - 2 + 4) % 4 : (s + 2) % 4;
          xs = {xs, (cx[idx] + cx[nxt]) / 2}; ys = {ys, (cy[idx] + cy[nxt]) / 2};
        end
      end
    end else if (kind < 60) begin
      n = $urandom_range(3, 8);
      span = $urandom_range(4, 160);
      x0 = $urandom_range(0, 1023);
      y0 = $urandom_range(0, 1023);
      repeat (n) begin
        w = x0 + $urandom_range(0, span);
        h = y0 + $urandom_range(0, span);
        xs = {xs, (w > 1023 ? 1023 : w)}; ys = {ys, (h > 1023 ? 1023 : h)};
      end
    end else if (kind < 82) begin
      n = $urandom_range(2, 10);
      repeat (n) begin
        xs = {xs, int'($urandom_range(0, 1023))}; ys = {ys, int'($urandom_range(0, 1023))};
      end
    end else if (kind < 90) begin
      n = $urandom_range(1, 2);
      repeat (n) begin
        xs = {xs, int'($urandom_range(0, 1023))}; ys = {ys, int'($urandom_range(0, 1023))};
      end
    end else if (kind < 94) begin
      n = $urandom_range(3, 6);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: xs = {xs, 0};
          1: xs = {xs, 1023};
          default: xs = {xs, int'($urandom_range(0, 1023))};
        endcase
        case ($urandom_range(0, 2))
          0: ys = {ys, 0};
          1: ys = {ys, 1023};
          default: ys = {ys, int'($urandom_range(0, 1023))};
        endcase
      end
    end else if (kind < 97) begin
      n = $urandom_range(2, 5);
      x0 = $urandom_range(0, 1023);
      y0 = $urandom_range(0, 1023);
      rev = $urandom_range(0, 1);
      repeat (n) begin
        xs = {xs, (rev ? x0 : int'($urandom_range(0, 1023)))};
        ys = {ys, (rev ? int'($urandom_range(0, 1023)) : y0)};
      end
    end else begin
      square_windings($urandom_range(0, 40), $urandom_range(980, 1023), $urandom_range(2, 5));
      return;
    end
    send_contour(xs, ys);
  endtask

  initial begin
    int mins[6];
    int maxs[6];
    int asps[6];
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= cpc_pkg::CFG_MIN_AREA;
    cfg_data <= '0;
    pin.valid <= 1'b0;
    pin.point_x <= '0;
    pin.point_y <= '0;
    pin.last_point <= 1'b0;
    mins = '{499, 0, 5000, 200, 8191, $urandom_range(0, 5000)};
    maxs = '{750, 7500, 0, 400, 8191, $urandom_range(0, 7500)};
    asps = '{99, 0, 500, 150, 511, $urandom_range(0, 500)};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_point(0, 0, 1);
    send_point(1023, 1023, 1);
    square_windings(0, 1023, 1);
    send_point(100, 100, 0);
    send_point(100, 130, 0);
    send_point(120, 130, 0);
    send_point(120, 100, 1);
    send_point(5, 0, 0);
    send_point(5, 40, 1);
    square_windings(0, 1023, 3);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        pause_until_drained(8);
        program_limits(mins[p], maxs[p], asps[p]);
      end
      phase_points = 0;
      while (phase_points < PHASE_POINTS) random_contour();
    end

    pause_until_drained(12);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    bit held;
    int style, len, tick;
    held = 0;
    tick = 0;
    forever begin
      if (!held && points_taken >= HOLD_AFTER) begin
        held = 1;
        rout.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      len = $urandom_range(1, 40);
      repeat (len) begin
        tick++;
        case (style)
          0: rout.ready <= 1'b1;
          1: rout.ready <= $urandom_range(0, 1);
          2: rout.ready <= ($urandom_range(0, 3) == 0);
          default: rout.ready <= (tick % 4 != 3);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t seen;
    if (!rst && rout.valid === 1'b1 && rout.ready === 1'b1) begin
      seen.is_person = rout.is_person;
      seen.estimate = rout.person_estimate;
      seen.twice_area = rout.twice_area;
      seen.width = rout.box_width;
      seen.height = rout.box_height;
      sb.match_verdict(seen);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((pin.valid === 1'b1 && pin.ready === 1'b1) ||
          (rout.valid === 1'b1 && rout.ready === 1'b1)) idle = 0;
      else idle++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule
